// ===== sv/ftcg_pkg.sv =====
// Shared types and constants of the force/torque calibration and guard block.
`timescale 1ns / 1ps
`default_nettype none
package ftcg_pkg;

  localparam int AXES     = 6;
  localparam int NCOEF    = AXES * AXES;
  localparam int COEF_AW  = 6;
  localparam int COL_W    = 3;
  localparam int GAUGE_W  = 32;
  localparam int VAL_W    = 40;
  localparam int LIM_W    = 39;
  localparam int PROD_W   = 2 * GAUGE_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int CFG_AW   = 3;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TARE   = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  localparam logic [CFG_AW-1:0] REG_GUARD_EN = 3'd6;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 40'sh80_0000_0000;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [GAUGE_W-1:0] gauge_0;
    logic signed [GAUGE_W-1:0] gauge_1;
    logic signed [GAUGE_W-1:0] gauge_2;
    logic signed [GAUGE_W-1:0] gauge_3;
    logic signed [GAUGE_W-1:0] gauge_4;
    logic signed [GAUGE_W-1:0] gauge_5;
    logic                      fault_active;
    logic [2:0]                coef_row;
    logic [2:0]                coef_col;
    logic signed [GAUGE_W-1:0] coef_value;
  } ftcg_in_t;

  typedef struct packed {
    logic [2:0]              axis;
    logic signed [VAL_W-1:0] raw_value;
    logic signed [VAL_W-1:0] tared_value;
    logic                    over_limit;
    logic                    guard_fault;
    logic                    status;
    logic                    last;
  } ftcg_out_t;

  // Travels with each coefficient read down the multiply-accumulate path.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [COL_W-1:0] col;
  } ftcg_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_AXIS,
    ST_ONE
  } ftcg_state_t;

endpackage
`default_nettype wire

// ===== sv/ftcg_coef_mem.sv =====
// Calibration coefficient memory: 36 x 32 bits, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ftcg_coef_mem (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [ftcg_pkg::COEF_AW-1:0]      wr_addr,
  input  wire logic signed [ftcg_pkg::GAUGE_W-1:0] wr_data,
  input  wire logic                              rd_en,
  input  wire logic [ftcg_pkg::COEF_AW-1:0]      rd_addr,
  input  wire ftcg_pkg::ftcg_tag_t               rd_tag,
  output logic signed [ftcg_pkg::GAUGE_W-1:0]    rd_data,
  output ftcg_pkg::ftcg_tag_t                    rd_tag_q
);
  import ftcg_pkg::*;

  logic signed [GAUGE_W-1:0] mem [NCOEF];
  logic [NCOEF-1:0]          entry_vld;
  logic signed [GAUGE_W-1:0] rd_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= entry_vld[rd_addr];
    end
  end

  // Entries never loaded since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_tag_q  <= '0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      rd_tag_q <= rd_tag;
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== sv/ftcg_mac.sv =====
// Multiply-accumulate unit: registered 32x32 product, then a 67-bit accumulator.
`timescale 1ns / 1ps
`default_nettype none
module ftcg_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [ftcg_pkg::GAUGE_W-1:0] coef,
  input  wire logic signed [ftcg_pkg::GAUGE_W-1:0] gauge,
  input  wire ftcg_pkg::ftcg_tag_t                 tag,
  output logic signed [ftcg_pkg::ACC_W-1:0]        acc,
  output logic                                     done
);
  import ftcg_pkg::*;

  logic signed [PROD_W-1:0] prod;
  ftcg_tag_t                tag1;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    prod <= coef * gauge;
    if (tag1.vld) begin
      acc <= tag1.first ? prod_ext : acc + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      done <= 1'b0;
    end else begin
      tag1 <= tag;
      done <= tag1.vld && tag1.last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/force_torque_calibrate_guard.sv =====
// Top level of the six-axis force/torque calibration and guard block.
`timescale 1ns / 1ps
`default_nettype none
// A sample request is accepted in the idle state. Then, for each of the six
// axes, six coefficient reads from the calibration memory's single read port
// feed one shared 32x32 multiplier, one coefficient read per cycle. The read
// data, the product and the accumulator are registered in turn, the sum is
// rounded into the raw result register, and the result is then loaded into
// the output register; a stalled output holds back the next axis. Tare and
// load requests pass through a single state that loads the output register. A
// new request is taken as soon as the final result of the previous one sits in
// the output register.
// The coefficient memory needs no clearing pass: per-entry valid bits make
// unloaded coefficients read as zero right after reset.
module force_torque_calibrate_guard (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ftcg_pkg::ftcg_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ftcg_pkg::ftcg_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [ftcg_pkg::CFG_AW-1:0]     cfg_addr,
  input  wire logic [ftcg_pkg::LIM_W-1:0]      cfg_wdata
);
  import ftcg_pkg::*;

  ftcg_state_t state, state_next;

  ftcg_in_t                  item;
  logic [COEF_AW-1:0]        coef_addr;
  logic [COL_W-1:0]          col_cnt;
  logic [2:0]                axis_cnt;
  logic                      any_over;
  logic signed [VAL_W-1:0]   raw_q;
  logic signed [VAL_W-1:0]   tare_offset [AXES];
  logic signed [VAL_W-1:0]   last_wrench [AXES];
  logic [LIM_W-1:0]          limits [AXES];
  logic                      guard_en;

  logic                      in_fire;
  logic                      out_free;
  logic                      out_load;
  logic                      rd_en;
  ftcg_tag_t                 rd_tag;
  ftcg_tag_t                 rd_tag_q;
  logic signed [GAUGE_W-1:0] rd_data;
  logic signed [GAUGE_W-1:0] gauge_sel;
  logic signed [ACC_W-1:0]   acc;
  logic                      mac_done;
  logic                      wr_en;
  logic [COEF_AW-1:0]        wr_addr;
  logic [COEF_AW-1:0]        row_ext;
  logic [COEF_AW-1:0]        col_ext;

  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [VAL_W-1:0]   raw_next;
  logic signed [VAL_W:0]     tared_sum;
  logic signed [VAL_W-1:0]   tared_val;
  logic [VAL_W:0]            raw_mag;
  logic                      over;
  ftcg_out_t                 out_next;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Load address row*6+col.
  assign row_ext = {3'b000, in_data.coef_row};
  assign col_ext = {3'b000, in_data.coef_col};
  assign wr_addr = (row_ext << 2) + (row_ext << 1) + col_ext;
  assign wr_en   = in_fire && (in_data.kind == KIND_LOAD) &&
                   (in_data.coef_row < 3'(AXES)) && (in_data.coef_col < 3'(AXES));

  assign rd_tag.vld   = rd_en;
  assign rd_tag.first = (col_cnt == '0);
  assign rd_tag.last  = (col_cnt == COL_W'(AXES - 1));
  assign rd_tag.col   = col_cnt;

  ftcg_coef_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_data.coef_value),
    .rd_en    (rd_en),
    .rd_addr  (coef_addr),
    .rd_tag   (rd_tag),
    .rd_data  (rd_data),
    .rd_tag_q (rd_tag_q)
  );

  always_comb begin
    unique case (rd_tag_q.col)
      3'd0:    gauge_sel = item.gauge_0;
      3'd1:    gauge_sel = item.gauge_1;
      3'd2:    gauge_sel = item.gauge_2;
      3'd3:    gauge_sel = item.gauge_3;
      3'd4:    gauge_sel = item.gauge_4;
      3'd5:    gauge_sel = item.gauge_5;
      default: gauge_sel = '0;
    endcase
  end

  ftcg_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .coef  (rd_data),
    .gauge (gauge_sel),
    .tag   (rd_tag_q),
    .acc   (acc),
    .done  (mac_done)
  );

  // Round to nearest (ties up), drop 16 fraction bits, saturate to 40 bits.
  assign rnd_sum = acc + ACC_W'(32768);
  always_comb begin
    if (!rnd_sum[ACC_W-1] && (|rnd_sum[ACC_W-2:VAL_W+15])) begin
      raw_next = VAL_MAX;
    end else if (rnd_sum[ACC_W-1] && !(&rnd_sum[ACC_W-2:VAL_W+15])) begin
      raw_next = VAL_MIN;
    end else begin
      raw_next = rnd_sum[VAL_W+15:16];
    end
  end

  assign tared_sum = {raw_q[VAL_W-1], raw_q} + {tare_offset[axis_cnt][VAL_W-1],
                                                tare_offset[axis_cnt]};
  always_comb begin
    if (tared_sum[VAL_W] != tared_sum[VAL_W-1]) begin
      tared_val = tared_sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      tared_val = tared_sum[VAL_W-1:0];
    end
  end

  assign raw_mag = raw_q[VAL_W-1] ? (41'd0 - {raw_q[VAL_W-1], raw_q})
                                  : {raw_q[VAL_W-1], raw_q};
  assign over    = raw_mag > {2'b00, limits[axis_cnt]};

  always_comb begin
    out_next = '0;
    out_next.last = 1'b1;
    if (state == ST_AXIS) begin
      out_next.axis        = axis_cnt;
      out_next.raw_value   = raw_q;
      out_next.tared_value = tared_val;
      out_next.over_limit  = over;
      out_next.last        = (axis_cnt == 3'(AXES - 1));
      out_next.guard_fault = out_next.last && guard_en && !item.fault_active &&
                             (any_over || over);
      out_next.status      = STATUS_OK;
    end else begin
      out_next.status = ((item.kind == KIND_TARE) && item.fault_active) ? STATUS_REFUSED
                                                                        : STATUS_OK;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_SAMPLE) begin
            state_next = ST_ISSUE;
          end else if ((in_data.kind == KIND_TARE) || (in_data.kind == KIND_LOAD)) begin
            state_next = ST_ONE;
          end
        end
      end
      ST_ISSUE: begin
        if (col_cnt == COL_W'(AXES - 1)) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (out_free) begin
          state_next = (axis_cnt == 3'(AXES - 1)) ? ST_IDLE : ST_ISSUE;
        end
      end
      ST_ONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    rd_en    = (state == ST_ISSUE);
    out_load = ((state == ST_AXIS) || (state == ST_ONE)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
    if (state == ST_WAIT && mac_done) begin
      raw_q <= raw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_addr <= '0;
      col_cnt   <= '0;
      axis_cnt  <= '0;
      any_over  <= 1'b0;
    end else if (in_fire) begin
      coef_addr <= '0;
      col_cnt   <= '0;
      axis_cnt  <= '0;
      any_over  <= 1'b0;
    end else if (rd_en) begin
      coef_addr <= coef_addr + 1'b1;
      col_cnt   <= (col_cnt == COL_W'(AXES - 1)) ? '0 : col_cnt + 1'b1;
    end else if (state == ST_AXIS && out_free) begin
      any_over <= any_over || over;
      axis_cnt <= axis_cnt + 1'b1;
    end
  end

  // Wrench and tare offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        tare_offset[i] <= '0;
        last_wrench[i] <= '0;
      end
    end else begin
      if (state == ST_AXIS && out_free) begin
        last_wrench[axis_cnt] <= raw_q;
      end
      if (in_fire && (in_data.kind == KIND_TARE) && !in_data.fault_active) begin
        for (int i = 0; i < AXES; i++) begin
          tare_offset[i] <= (last_wrench[i] == VAL_MIN) ? VAL_MAX : -last_wrench[i];
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        limits[i] <= '1;
      end
      guard_en <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr < CFG_AW'(AXES)) begin
        limits[cfg_addr] <= cfg_wdata;
      end else if (cfg_addr == REG_GUARD_EN) begin
        guard_en <= cfg_wdata[0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  a_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_WAIT))
    else $error("accumulator finished outside the wait state");

  a_addr_range : assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (coef_addr < COEF_AW'(NCOEF)))
    else $error("coefficient read beyond the matrix");

  a_sample_start : assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.kind == KIND_SAMPLE)) |=> (state == ST_ISSUE))
    else $error("sample request did not start the matrix walk");

  a_guard_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.guard_fault) |-> (out_data.last && guard_en))
    else $error("guard fault on a non-final result or with the guard off");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the six-axis force/torque calibration and guard block.
`timescale 1ns / 1ps
module tb_top;
  import ftcg_pkg::*;

  localparam int WIDE_W = ACC_W + 3;
  localparam int RANDOM_ITEMS = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_FORCE_X = 3'd0;

  typedef enum int {LIM_MODERATE, LIM_ZERO, LIM_WIDE, LIM_MAXED, LIM_MIXED} limit_mode_t;

  // Tracks calibration state and the axis results each request must produce.
  class wrench_tracker_t;
    logic signed [GAUGE_W-1:0] coef [NCOEF];
    logic signed [VAL_W-1:0]   offset [AXES];
    logic signed [VAL_W-1:0]   wrench [AXES];
    logic [LIM_W-1:0]          limit [AXES];
    logic                      guard_en;
    ftcg_out_t                 axis_results_due [$];
    int mismatches, unexpected, results_seen;
    int samples, tares, refused, loads, over_flags, guard_trips, saturated;

    function new();
      for (int k = 0; k < NCOEF; k++) coef[k] = '0;
      for (int a = 0; a < AXES; a++) begin
        offset[a] = '0;
        wrench[a] = '0;
        limit[a]  = '1;
      end
      guard_en = 1'b0;
    endfunction

    function logic signed [VAL_W-1:0] clamp40(logic signed [WIDE_W-1:0] v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v[VAL_W-1:0];
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [LIM_W-1:0] data);
      if (addr < AXES) limit[addr] = data;
      else if (addr == REG_GUARD_EN) guard_en = data[0];
    endfunction

    function void note_request(ftcg_in_t req);
      logic signed [GAUGE_W-1:0] g [AXES];
      logic signed [WIDE_W-1:0]  acc;
      logic signed [WIDE_W-1:0]  t;
      logic signed [VAL_W-1:0]   r;
      logic [VAL_W-1:0]          mag;
      longint                    pa, pb;
      logic                      any_over;
      ftcg_out_t                 res;
      res = '0;
      case (req.kind)
        KIND_SAMPLE: begin
          g[0] = req.gauge_0; g[1] = req.gauge_1; g[2] = req.gauge_2;
          g[3] = req.gauge_3; g[4] = req.gauge_4; g[5] = req.gauge_5;
          any_over = 1'b0;
          samples++;
          for (int a = 0; a < AXES; a++) begin
            acc = '0;
            for (int c = 0; c < AXES; c++) begin
              pa = longint'(coef[a * AXES + c]);
              pb = longint'(g[c]);
              acc = acc + pa * pb;
            end
            // round to nearest, ties toward plus infinity
            acc = (acc + 32'sd32768) >>> 16;
            r = clamp40(acc);
            if (r == VAL_MAX || r == VAL_MIN) saturated++;
            wrench[a] = r;
            mag = r[VAL_W-1] ? (~r + 1'b1) : r;
            res.axis = a[2:0];
            res.raw_value = r;
            t = WIDE_W'(r);
            t = t + offset[a];
            res.tared_value = clamp40(t);
            res.over_limit = (mag > {1'b0, limit[a]});
            if (res.over_limit) begin
              any_over = 1'b1;
              over_flags++;
            end
            res.status = STATUS_OK;
            res.last = (a == AXES - 1);
            res.guard_fault = (a == AXES - 1) && guard_en && !req.fault_active && any_over;
            if (res.guard_fault) guard_trips++;
            axis_results_due.push_back(res);
          end
        end
        KIND_TARE: begin
          tares++;
          res.last = 1'b1;
          if (req.fault_active) begin
            res.status = STATUS_REFUSED;
            refused++;
          end else begin
            res.status = STATUS_OK;
            for (int a = 0; a < AXES; a++) begin
              t = '0;
              t = t - wrench[a];
              offset[a] = clamp40(t);
            end
          end
          axis_results_due.push_back(res);
        end
        KIND_LOAD: begin
          loads++;
          if (req.coef_row < AXES && req.coef_col < AXES)
            coef[req.coef_row * AXES + req.coef_col] = req.coef_value;
          res.status = STATUS_OK;
          res.last = 1'b1;
          axis_results_due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(ftcg_out_t got);
      ftcg_out_t want;
      results_seen++;
      if (axis_results_due.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: axis %0d raw %h tared %h", got.axis, got.raw_value,
                   got.tared_value);
        return;
      end
      want = axis_results_due.pop_front();
      if (got.axis !== want.axis || got.raw_value !== want.raw_value ||
          got.tared_value !== want.tared_value || got.over_limit !== want.over_limit ||
          got.guard_fault !== want.guard_fault || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("mismatch at %0t: axis exp %0d got %0d, raw exp %h got %h", $realtime,
                   want.axis, got.axis, want.raw_value, got.raw_value);
          $display("  tared exp %h got %h, over/gf/status/last exp %b%b%b%b got %b%b%b%b",
                   want.tared_value, got.tared_value, want.over_limit, want.guard_fault,
                   want.status, want.last, got.over_limit, got.guard_fault, got.status,
                   got.last);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ftcg_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ftcg_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [LIM_W-1:0]  cfg_wdata = '0;

  wrench_tracker_t tracker;
  int burst_left = 0;
  int sent_items = 0;
  int rx_cycle = 0;
  int stall_left = 0;
  int quiet = 0;

  force_torque_calibrate_guard dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: cycle through always-ready, periodic, random and long-stall modes.
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 97) % 4)
      0: out_ready = 1'b1;
      1: out_ready = (rx_cycle % 4) != 0;
      2: out_ready = ($urandom_range(0, 9) < 3);
      default: begin
        if (stall_left > 0) begin
          out_ready = 1'b0;
          stall_left--;
        end else begin
          out_ready = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [GAUGE_W-1:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = '0;
      3: v = '1;
      4, 5: v = $urandom();
      default: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic ftcg_in_t random_request(logic [1:0] kind);
    ftcg_in_t r;
    r.kind = kind;
    r.gauge_0 = rand_q(); r.gauge_1 = rand_q(); r.gauge_2 = rand_q();
    r.gauge_3 = rand_q(); r.gauge_4 = rand_q(); r.gauge_5 = rand_q();
    r.fault_active = ($urandom_range(0, 3) == 0);
    r.coef_row = 3'($urandom_range(0, 5));
    r.coef_col = 3'($urandom_range(0, 5));
    r.coef_value = rand_q();
    return r;
  endfunction

  function automatic ftcg_in_t load_request(logic [2:0] row, logic [2:0] col,
                                            logic signed [GAUGE_W-1:0] value);
    ftcg_in_t r;
    r = '0;
    r.kind = KIND_LOAD;
    r.coef_row = row;
    r.coef_col = col;
    r.coef_value = value;
    return r;
  endfunction

  function automatic ftcg_in_t sample_request(logic signed [GAUGE_W-1:0] g0,
                                              logic signed [GAUGE_W-1:0] g_rest,
                                              logic fault);
    ftcg_in_t r;
    r = '0;
    r.kind = KIND_SAMPLE;
    r.gauge_0 = g0;
    r.gauge_1 = g_rest; r.gauge_2 = g_rest; r.gauge_3 = g_rest;
    r.gauge_4 = g_rest; r.gauge_5 = g_rest;
    r.fault_active = fault;
    return r;
  endfunction

  // Send one request; the sender runs in bursts separated by random gaps.
  task automatic push_request(ftcg_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_data = req;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_request(req);
    burst_left--;
    if (req.kind != KIND_UNUSED) sent_items++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline drain.
  task automatic settle(int hold);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.axis_results_due.size() != 0) @(posedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_AW-1:0] addr, logic [LIM_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(posedge clk);
    tracker.write_reg(addr, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(limit_mode_t mode, logic guard);
    logic [LIM_W-1:0] lim;
    logic [63:0]      w;
    for (int a = 0; a < AXES; a++) begin
      w = {$urandom(), $urandom()};
      case (mode)
        LIM_MODERATE: lim = LIM_W'($urandom_range(0, 32'h3FFF_FFFF));
        LIM_ZERO:     lim = '0;
        LIM_WIDE:     lim = w[LIM_W-1:0];
        LIM_MAXED:    lim = '1;
        default: begin
          case ($urandom_range(0, 3))
            0: lim = '0;
            1: lim = '1;
            2: lim = w[LIM_W-1:0];
            default: lim = LIM_W'($urandom_range(0, 32'h0FFF_FFFF));
          endcase
        end
      endcase
      write_cfg(REG_MAX_FORCE_X + CFG_AW'(a), lim);
    end
    write_cfg(REG_GUARD_EN, LIM_W'(guard));
  endtask

  initial begin
    ftcg_in_t req;
    int       phase;
    int       base;
    int       n;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty matrix, tare refused and accepted, extreme coefficients,
    // out-of-range positions, saturation both ways, rounding ties, ignored kind.
    push_request(sample_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    req = '0;
    req.kind = KIND_TARE;
    req.fault_active = 1'b1;
    push_request(req);
    req.fault_active = 1'b0;
    push_request(req);
    push_request(load_request(3'd0, 3'd0, 32'h8000_0000));
    push_request(load_request(3'd1, 3'd0, 32'h7FFF_FFFF));
    push_request(load_request(3'd2, 3'd0, 32'h0000_0001));
    push_request(load_request(3'd3, 3'd5, 32'hFFFF_FFFF));
    push_request(load_request(3'd4, 3'd2, $urandom()));
    push_request(load_request(3'd6, 3'd0, 32'h7FFF_FFFF));
    push_request(load_request(3'd0, 3'd7, 32'h7FFF_FFFF));
    push_request(load_request(3'd7, 3'd7, 32'h8000_0000));
    push_request(sample_request(32'h8000_0000, 32'h8000_0000, 1'b0));
    push_request(req);
    push_request(sample_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    push_request(sample_request(32'h0000_8000, 32'h0, 1'b0));
    push_request(sample_request(32'hFFFF_8000, 32'h0, 1'b0));
    push_request(sample_request(32'h0001_8000, 32'h0, 1'b0));
    push_request(random_request(KIND_UNUSED));

    // Guard: zero limits, device fault gating, and an all-zero wrench.
    settle(80);
    apply_setting(LIM_ZERO, 1'b1);
    push_request(sample_request(rand_q(), rand_q(), 1'b1));
    push_request(sample_request(rand_q(), rand_q(), 1'b0));
    push_request(sample_request(32'h0, 32'h0, 1'b0));
    req.fault_active = 1'b1;
    push_request(req);

    settle(80);
    apply_setting(LIM_MODERATE, 1'b1);
    phase = 0;
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (phase < 4 && sent_items - base >= (phase + 1) * (RANDOM_ITEMS / 5)) begin
        phase++;
        settle(80);
        case (phase)
          1: apply_setting(LIM_ZERO, 1'b1);
          2: apply_setting(LIM_WIDE, 1'b0);
          3: apply_setting(LIM_MAXED, 1'b1);
          default: apply_setting(LIM_MIXED, 1'($urandom_range(0, 1)));
        endcase
      end
      n = $urandom_range(0, 9);
      if (n < 5) begin
        // recalibrate a few coefficients, then measure and maybe re-zero
        repeat ($urandom_range(1, 8)) push_request(random_request(KIND_LOAD));
        repeat ($urandom_range(1, 4)) push_request(random_request(KIND_SAMPLE));
        if ($urandom_range(0, 1) == 1) begin
          req = random_request(KIND_TARE);
          req.fault_active = 1'b0;
          push_request(req);
          repeat ($urandom_range(1, 2)) push_request(random_request(KIND_SAMPLE));
        end
      end else if (n < 8) begin
        repeat ($urandom_range(1, 4))
          push_request(random_request(($urandom_range(0, 9) < 7) ? KIND_SAMPLE : KIND_TARE));
      end else begin
        case ($urandom_range(0, 2))
          0: push_request(random_request(KIND_UNUSED));
          1: begin
            req = random_request(KIND_LOAD);
            if ($urandom_range(0, 1) == 1) req.coef_row = 3'($urandom_range(6, 7));
            else req.coef_col = 3'($urandom_range(6, 7));
            push_request(req);
          end
          default: begin
            req = random_request(KIND_TARE);
            req.fault_active = 1'b1;
            push_request(req);
          end
        endcase
      end
    end

    settle(100);
    $display("covered %0d samples, %0d tares (%0d refused), %0d coefficient loads, %0d results",
             tracker.samples, tracker.tares, tracker.refused, tracker.loads,
             tracker.results_seen);
    $display("over-limit flags %0d, guard trips %0d, saturated axes %0d, bad %0d, stray %0d",
             tracker.over_flags, tracker.guard_trips, tracker.saturated, tracker.mismatches,
             tracker.unexpected);
    if (tracker.mismatches == 0 && tracker.unexpected == 0 &&
        tracker.axis_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
